FILE: sv/fccs_pkg.sv
// shared types and constants of the friction contact case solver
package fccs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_LSB_DEF   = 7;

  localparam int M_W   = 34;
  localparam int OP_W  = 35;
  localparam int COF_W = 66;
  localparam int DET_W = 100;
  localparam int V_W   = 66;
  localparam int Q_W   = 34;

  localparam logic [1:0] CASE_NEG   = 2'd0;
  localparam logic [1:0] CASE_STICK = 2'd1;
  localparam logic [1:0] CASE_POS   = 2'd2;
  localparam logic [1:0] COL_NONE   = 2'd3;

  typedef struct packed {
    logic en;
    logic to_cof;
    logic clr;
    logic neg;
    logic sh32;
  } mac_op_t;

endpackage

FILE: sv/fccs_mac.sv
// shared multiply-accumulate unit with cofactor and wide accumulators
module fccs_mac (
  input  logic                                  clk,
  input  fccs_pkg::mac_op_t                     op,
  input  logic signed [fccs_pkg::OP_W-1:0]      opa,
  input  logic signed [fccs_pkg::OP_W-1:0]      opb,
  input  logic signed [fccs_pkg::DET_W-1:0]     init,
  output logic signed [fccs_pkg::DET_W-1:0]     acc,
  output logic signed [fccs_pkg::COF_W-1:0]     cof
);
  import fccs_pkg::*;

  logic signed [2*OP_W-1:0]  prod;
  logic signed [DET_W-1:0]   pext;
  logic signed [DET_W-1:0]   pterm;
  logic signed [COF_W-1:0]   cterm;

  assign prod = opa * opb;

  always_comb begin
    pext = DET_W'(prod);
    if (op.sh32) begin
      pext = pext <<< 32;
    end
    pterm = op.neg ? -pext : pext;
    cterm = op.neg ? -COF_W'(prod) : COF_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      if (op.to_cof) begin
        cof <= (op.clr ? COF_W'(0) : cof) + cterm;
      end else begin
        acc <= (op.clr ? init : acc) + pterm;
      end
    end
  end

endmodule

FILE: sv/fccs_div.sv
// restoring divider with round half away from zero and 32-bit saturation
module fccs_div #(
  parameter int FRAC_BITS = fccs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [fccs_pkg::DET_W-1:0]  n,
  input  logic signed [fccs_pkg::DET_W-1:0]  d,
  output logic                               done,
  output logic signed [31:0]                 res
);
  import fccs_pkg::*;

  localparam int CW    = DET_W + FRAC_BITS + 35;
  localparam int CNT_W = $clog2(Q_W);

  logic [DET_W-1:0] n_abs;
  logic [DET_W-1:0] d_abs;
  logic [CW-1:0]    num;
  logic [CW-1:0]    den0;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsh;
  logic [CW-1:0]    rem_next;
  logic [Q_W-1:0]   q;
  logic [Q_W-1:0]   q_next;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             ovf;
  logic             busy;
  logic             ge;
  logic signed [31:0] fin;

  always_comb begin
    n_abs    = n[DET_W-1] ? DET_W'(-n) : DET_W'(n);
    d_abs    = d[DET_W-1] ? DET_W'(-d) : DET_W'(d);
    num      = (CW'(n_abs) << (FRAC_BITS + 1)) + CW'(d_abs);
    den0     = CW'(d_abs) << Q_W;
    ge       = rem >= dsh;
    rem_next = ge ? rem - dsh : rem;
    q_next   = {q[Q_W-2:0], ge};
    if (neg) begin
      if (ovf || (q_next > Q_W'(64'h8000_0000))) begin
        fin = 32'sh8000_0000;
      end else begin
        fin = -$signed(q_next[31:0]);
      end
    end else begin
      if (ovf || (q_next[Q_W-1:31] != '0)) begin
        fin = 32'sh7fff_ffff;
      end else begin
        fin = $signed(q_next[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        rem  <= num;
        dsh  <= den0;
        q    <= '0;
        neg  <= n[DET_W-1] ^ d[DET_W-1];
        ovf  <= num >= (CW'(d_abs) << (Q_W + 1));
        cnt  <= CNT_W'(Q_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        dsh <= dsh >> 1;
        q   <= q_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          res  <= fin;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/friction_contact_case_solver.sv
// friction contact case solver: one contact's 3x3 boxed LCP by case enumeration
//
// An item is taken on the item channel (item_valid high, item_stall low): the six
// entries of the symmetric block, the bias vector and the friction coefficient.
// One result beat per item leaves on the result channel: the three impulses,
// found and separated. item_stall is high from the beat after acceptance until
// the sequencer returns to idle, so one item is in work at a time.
// A separated contact goes from S_START straight to S_OUT. A case that runs all
// its checks uses four determinants on the shared multiply-accumulate unit, three
// divisions, the velocity products and the sequencing and checks; a singular case
// stops after its first determinant. Up to nine cases run, one after another on
// the one multiplier and the one divider.
// The result sits in an output register; while result_stall is high it holds,
// and a new item may already be accepted behind it. A finished result waits in
// the sequencer until the output register frees up.
// rst (synchronous, active high) clears the sequencer, the divider and
// result_valid; no item or result survives it.
module friction_contact_case_solver #(
  parameter int FRAC_BITS = fccs_pkg::FRAC_BITS_DEF,
  parameter int EPS_LSB   = fccs_pkg::EPS_LSB_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] a_nn,
  input  logic signed [31:0] a_n_t1,
  input  logic signed [31:0] a_n_t2,
  input  logic signed [31:0] a_t1_t1,
  input  logic signed [31:0] a_t1_t2,
  input  logic signed [31:0] a_t2_t2,
  input  logic signed [31:0] bias_n,
  input  logic signed [31:0] bias_t1,
  input  logic signed [31:0] bias_t2,
  input  logic [18:0]        friction,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] impulse_n,
  output logic signed [31:0] impulse_t1,
  output logic signed [31:0] impulse_t2,
  output logic               found,
  output logic               separated
);
  import fccs_pkg::*;

  localparam logic signed [V_W-1:0] E2     = V_W'(EPS_LSB) <<< FRAC_BITS;
  localparam logic signed [31:0]    NEG_E32 = -32'(EPS_LSB);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DET, S_DETDONE, S_DIV, S_CHK0,
    S_VEL, S_VSAVE, S_UP, S_CHK, S_NEXT, S_OUT
  } state_t;

  state_t state;

  logic signed [31:0]      areg [3][3];
  logic signed [31:0]      xreg [3];
  logic [18:0]             mu;
  logic [1:0]              c1, c2, col, row, jj;
  logic [3:0]              step;
  logic signed [DET_W-1:0] det;
  logic signed [31:0]      lres [3];
  logic signed [V_W-1:0]   vreg [3];
  logic signed [31:0]      res_n, res_t1, res_t2;
  logic                    res_found, res_sep;

  logic signed [M_W-1:0]   mat [3][3];
  mac_op_t                 op;
  logic signed [OP_W-1:0]  opa, opb;
  logic signed [DET_W-1:0] init;
  logic signed [DET_W-1:0] acc;
  logic signed [COF_W-1:0] cof;
  logic                    div_start, div_done;
  logic signed [31:0]      div_res;
  logic signed [V_W-1:0]   up;
  logic                    chk_pass;

  logic [1:0]              code;
  logic signed [M_W-1:0]   kval, bval, muv;
  logic [1:0]              term, sub, ca, cb;

  function automatic logic tan_ok(logic signed [31:0] lt, logic signed [V_W-1:0] upv,
                                  logic signed [V_W-1:0] v, logic [1:0] cs);
    logic signed [V_W-1:0] t, dl, du;
    logic ok;
    t  = V_W'(lt) <<< FRAC_BITS;
    dl = t + upv;
    du = t - upv;
    case (cs)
      CASE_STICK: ok = (t >= -upv - E2) && (t <= upv + E2) && (v <= E2) && (v >= -E2);
      CASE_NEG:   ok = (dl <= E2) && (dl >= -E2) && (v >= -E2);
      CASE_POS:   ok = (du <= E2) && (du >= -E2) && (v <= E2);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign item_stall = (state != S_IDLE);

  // case matrix with the selected column, if any, replaced by the right-hand side
  always_comb begin
    muv = M_W'($signed({1'b0, mu}));
    for (int r = 0; r < 3; r++) begin
      for (int q = 0; q < 3; q++) begin
        code = (r == 1) ? c1 : c2;
        if (r == 0 || code == CASE_STICK) begin
          kval = M_W'(areg[r][q]);
          bval = -M_W'(xreg[r]);
        end else begin
          bval = '0;
          if (q == 0) begin
            kval = (code == CASE_NEG) ? muv : -muv;
          end else if (q == r) begin
            kval = M_W'(1) <<< FRAC_BITS;
          end else begin
            kval = '0;
          end
        end
        mat[r][q] = (2'(q) == col) ? bval : kval;
      end
    end
  end

  always_comb begin
    op   = '0;
    opa  = '0;
    opb  = '0;
    init = '0;
    term = step[3:2];
    sub  = step[1:0];
    ca   = (term == 2'd0) ? 2'd1 : 2'd0;
    cb   = (term == 2'd2) ? 2'd1 : 2'd2;
    case (state)
      S_DET: begin
        op.en = 1'b1;
        case (sub)
          2'd0: begin
            op.to_cof = 1'b1;
            op.clr    = 1'b1;
            opa       = OP_W'(mat[1][ca]);
            opb       = OP_W'(mat[2][cb]);
          end
          2'd1: begin
            op.to_cof = 1'b1;
            op.neg    = 1'b1;
            opa       = OP_W'(mat[1][cb]);
            opb       = OP_W'(mat[2][ca]);
          end
          2'd2: begin
            op.clr = (term == 2'd0);
            op.neg = (term == 2'd1);
            opa    = $signed({3'b000, cof[31:0]});
            opb    = OP_W'(mat[0][term]);
          end
          default: begin
            op.neg  = (term == 2'd1);
            op.sh32 = 1'b1;
            opa     = OP_W'($signed(cof[COF_W-1:32]));
            opb     = OP_W'(mat[0][term]);
          end
        endcase
      end
      S_VEL: begin
        op.en  = 1'b1;
        op.clr = (jj == 2'd0);
        opa    = OP_W'(areg[row][jj]);
        opb    = OP_W'(lres[jj]);
        init   = DET_W'(xreg[row]) <<< FRAC_BITS;
      end
      S_UP: begin
        op.en  = 1'b1;
        op.clr = 1'b1;
        opa    = OP_W'($signed({1'b0, mu}));
        opb    = OP_W'(lres[0]);
      end
      default: begin
        op = '0;
      end
    endcase
  end

  fccs_mac u_mac (
    .clk  (clk),
    .op   (op),
    .opa  (opa),
    .opb  (opb),
    .init (init),
    .acc  (acc),
    .cof  (cof)
  );

  assign div_start = (state == S_DETDONE) && (col != COL_NONE);

  fccs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (acc),
    .d     (det),
    .done  (div_done),
    .res   (div_res)
  );

  assign up       = acc[V_W-1:0];
  assign chk_pass = (vreg[0] <= E2) && (vreg[0] >= -E2) &&
                    tan_ok(lres[1], up, vreg[1], c1) &&
                    tan_ok(lres[2], up, vreg[2], c2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            areg[0][0] <= a_nn;
            areg[0][1] <= a_n_t1;
            areg[1][0] <= a_n_t1;
            areg[0][2] <= a_n_t2;
            areg[2][0] <= a_n_t2;
            areg[1][1] <= a_t1_t1;
            areg[1][2] <= a_t1_t2;
            areg[2][1] <= a_t1_t2;
            areg[2][2] <= a_t2_t2;
            xreg[0]    <= bias_n;
            xreg[1]    <= bias_t1;
            xreg[2]    <= bias_t2;
            mu         <= friction;
            state      <= S_START;
          end
        end
        S_START: begin
          res_n  <= '0;
          res_t1 <= '0;
          res_t2 <= '0;
          if (xreg[0] >= NEG_E32) begin
            res_found <= 1'b1;
            res_sep   <= 1'b1;
            state     <= S_OUT;
          end else begin
            res_found <= 1'b0;
            res_sep   <= 1'b0;
            c1        <= CASE_NEG;
            c2        <= CASE_NEG;
            col       <= COL_NONE;
            step      <= '0;
            state     <= S_DET;
          end
        end
        S_DET: begin
          step <= step + 1'b1;
          if (step == 4'd11) begin
            state <= S_DETDONE;
          end
        end
        S_DETDONE: begin
          step <= '0;
          if (col == COL_NONE) begin
            if (acc == '0) begin
              state <= S_NEXT;
            end else begin
              det   <= acc;
              col   <= 2'd0;
              state <= S_DET;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            lres[col] <= div_res;
            if (col == 2'd2) begin
              state <= S_CHK0;
            end else begin
              col   <= col + 1'b1;
              state <= S_DET;
            end
          end
        end
        S_CHK0: begin
          row <= '0;
          jj  <= '0;
          if (lres[0] < NEG_E32) begin
            state <= S_NEXT;
          end else begin
            state <= S_VEL;
          end
        end
        S_VEL: begin
          jj <= jj + 1'b1;
          if (jj == 2'd2) begin
            state <= S_VSAVE;
          end
        end
        S_VSAVE: begin
          vreg[row] <= acc[V_W-1:0];
          jj        <= '0;
          if (row == 2'd2) begin
            state <= S_UP;
          end else begin
            row   <= row + 1'b1;
            state <= S_VEL;
          end
        end
        S_UP: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (chk_pass) begin
            res_n     <= lres[0];
            res_t1    <= lres[1];
            res_t2    <= lres[2];
            res_found <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          col  <= COL_NONE;
          step <= '0;
          if (c2 != CASE_POS) begin
            c2    <= c2 + 1'b1;
            state <= S_DET;
          end else if (c1 != CASE_POS) begin
            c1    <= c1 + 1'b1;
            c2    <= CASE_NEG;
            state <= S_DET;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            impulse_n    <= res_n;
            impulse_t1   <= res_t1;
            impulse_t2   <= res_t2;
            found        <= res_found;
            separated    <= res_sep;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sep_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && separated |-> found && impulse_n == '0 && impulse_t1 == '0 &&
    impulse_t2 == '0)
    else $error("separated result without found or with nonzero impulse");

  a_unsolved_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> impulse_n == '0 && impulse_t1 == '0 && impulse_t2 == '0)
    else $error("unsolved result carries an impulse");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("solver ready right after taking an item");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

endmodule
